FILE: rtl/cet_pkg.sv
// ----------------------------------------------------------------------------
// cet_pkg
// Shared constants and types for the compacting entry table.
// ----------------------------------------------------------------------------
package cet_pkg;

	localparam int MAX_ENTRIES = 16;
	localparam int ENTRY_WIDTH = 64;

	localparam int OP_W   = 2;
	localparam int IDX_W  = 8;
	localparam int DATA_W = 64;
	localparam int CNT_OUT_W = 5;

	localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
	localparam int ADDR_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

	typedef enum logic [OP_W-1:0] {
		OP_READ   = 2'd0,
		OP_WRITE  = 2'd1,
		OP_DELETE = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef struct packed {
		logic                   we;
		logic [ADDR_W-1:0]      waddr;
		logic [ENTRY_WIDTH-1:0] wdata;
		logic [ADDR_W-1:0]      raddr;
	} mem_req_t;

endpackage

FILE: rtl/cet_mem.sv
// ----------------------------------------------------------------------------
// cet_mem
// Entry storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module cet_mem (
	input  logic                            clk,
	input  cet_pkg::mem_req_t               req,
	output logic [cet_pkg::ENTRY_WIDTH-1:0] rdata
);

	logic [cet_pkg::ENTRY_WIDTH-1:0] mem [cet_pkg::MAX_ENTRIES];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		rdata <= mem[req.raddr];
	end

endmodule

FILE: rtl/cet_ctrl.sv
// ----------------------------------------------------------------------------
// cet_ctrl
// Request sequencer: decodes operations, owns the live count, walks the
// shift-down loop of a delete through the storage, and registers results.
// ----------------------------------------------------------------------------
module cet_ctrl (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [cet_pkg::OP_W-1:0]        operation,
	input  logic [cet_pkg::IDX_W-1:0]       index,
	input  logic [cet_pkg::DATA_W-1:0]      entry_data,
	output logic                            done,
	output logic                            ok,
	output logic [cet_pkg::DATA_W-1:0]      read_data,
	output logic [cet_pkg::CNT_OUT_W-1:0]   entry_count,
	output cet_pkg::mem_req_t               mem_req,
	input  logic [cet_pkg::ENTRY_WIDTH-1:0] mem_rdata
);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_RD    = 4'b0010,
		S_SH_RD = 4'b0100,
		S_SH_WR = 4'b1000
	} state_t;

	state_t                      state_q;
	logic [cet_pkg::CNT_W-1:0]   count_q;
	logic [cet_pkg::ADDR_W-1:0]  ptr_q;
	logic                        done_q;
	logic                        ok_q;
	logic [cet_pkg::DATA_W-1:0]  rdata_q;

	logic                        accept;
	cet_pkg::op_t                op;
	logic [cet_pkg::IDX_W-1:0]   count_ext;
	logic                        in_range;
	logic                        can_append;
	logic                        wr_ok;
	logic [cet_pkg::ADDR_W-1:0]  idx_addr;
	logic [cet_pkg::ADDR_W-1:0]  ptr_next;
	logic                        del_more;
	logic                        sh_more;

	assign accept     = start && (state_q == S_IDLE);
	assign busy       = (state_q != S_IDLE);
	assign op         = cet_pkg::op_t'(operation);
	assign count_ext  = cet_pkg::IDX_W'(count_q);
	assign in_range   = (index < count_ext);
	assign can_append = (index == count_ext) &&
		(count_q < cet_pkg::CNT_W'(cet_pkg::MAX_ENTRIES));
	assign wr_ok      = in_range || can_append;
	assign idx_addr   = cet_pkg::ADDR_W'(index);
	assign ptr_next   = ptr_q + cet_pkg::ADDR_W'(1);
	assign del_more   = (cet_pkg::CNT_W'(index) + cet_pkg::CNT_W'(1)) < count_q;
	assign sh_more    = (cet_pkg::CNT_W'(ptr_q) + cet_pkg::CNT_W'(2)) < count_q;

	always_comb begin
		mem_req = '0;
		mem_req.raddr = idx_addr;
		unique case (state_q)
			S_IDLE: begin
				mem_req.we    = accept && (op == cet_pkg::OP_WRITE) && wr_ok;
				mem_req.waddr = idx_addr;
				mem_req.wdata = cet_pkg::ENTRY_WIDTH'(entry_data);
			end
			S_RD: begin
			end
			S_SH_RD: begin
				mem_req.raddr = ptr_next;
			end
			S_SH_WR: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = ptr_q;
				mem_req.wdata = mem_rdata;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (op)
							cet_pkg::OP_READ: begin
								if (in_range) state_q <= S_RD;
								else done_q <= 1'b1;
							end
							cet_pkg::OP_WRITE: begin
								if (can_append) count_q <= count_q + cet_pkg::CNT_W'(1);
								done_q <= 1'b1;
							end
							cet_pkg::OP_DELETE: begin
								if (in_range && del_more) begin
									state_q <= S_SH_RD;
								end else begin
									if (in_range) count_q <= count_q - cet_pkg::CNT_W'(1);
									done_q <= 1'b1;
								end
							end
							cet_pkg::OP_CLEAR: begin
								count_q <= '0;
								done_q  <= 1'b1;
							end
							default: begin
							end
						endcase
					end
				end
				S_RD: begin
					state_q <= S_IDLE;
					done_q  <= 1'b1;
				end
				S_SH_RD: begin
					state_q <= S_SH_WR;
				end
				S_SH_WR: begin
					if (sh_more) begin
						state_q <= S_SH_RD;
					end else begin
						state_q <= S_IDLE;
						count_q <= count_q - cet_pkg::CNT_W'(1);
						done_q  <= 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result payload and shift pointer
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					ptr_q   <= idx_addr;
					rdata_q <= '0;
					unique case (op)
						cet_pkg::OP_READ:   ok_q <= in_range;
						cet_pkg::OP_WRITE:  ok_q <= wr_ok;
						cet_pkg::OP_DELETE: ok_q <= in_range;
						cet_pkg::OP_CLEAR:  ok_q <= 1'b1;
						default:            ok_q <= 1'b0;
					endcase
				end
			end
			S_RD: begin
				rdata_q <= cet_pkg::DATA_W'(mem_rdata);
			end
			S_SH_RD: begin
			end
			S_SH_WR: begin
				ptr_q <= ptr_next;
			end
			default: begin
			end
		endcase
	end

	assign done        = done_q;
	assign ok          = ok_q;
	assign read_data   = rdata_q;
	assign entry_count = cet_pkg::CNT_OUT_W'(count_q);

endmodule

FILE: rtl/compacting_entry_table_unit.sv
// ----------------------------------------------------------------------------
// compacting_entry_table_unit
// Densely packed table of entry words with a live count.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive operation, index and entry_data with start high;
//   the word is taken at a rising edge where start is high and busy is low.
//   Result channel: done pulses for one cycle with ok, read_data and
//   entry_count; the receiver must take it in that cycle.
// Sequencing (from the accept edge):
//   write, clear, failed request and single-step delete: done is high
//   in the cycle after the accept edge; successful read: the registered
//   memory read comes first, then the S_RD state; delete at index i with
//   count n moves n-1-i entries down, each through an S_SH_RD read state
//   and then an S_SH_WR write state.
// Throughput: one request at a time; busy is high until the result is
//   issued, and a new word may be taken in the cycle done is high.
// Reset: arst_n clears the count and the sequencer; stored words are
//   undefined and are only reachable after being written.
// ----------------------------------------------------------------------------
module compacting_entry_table_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [cet_pkg::OP_W-1:0]      operation,
	input  logic [cet_pkg::IDX_W-1:0]     index,
	input  logic [cet_pkg::DATA_W-1:0]    entry_data,
	output logic                          done,
	output logic                          ok,
	output logic [cet_pkg::DATA_W-1:0]    read_data,
	output logic [cet_pkg::CNT_OUT_W-1:0] entry_count
);

	cet_pkg::mem_req_t               mem_req;
	logic [cet_pkg::ENTRY_WIDTH-1:0] mem_rdata;

	cet_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.operation   (operation),
		.index       (index),
		.entry_data  (entry_data),
		.done        (done),
		.ok          (ok),
		.read_data   (read_data),
		.entry_count (entry_count),
		.mem_req     (mem_req),
		.mem_rdata   (mem_rdata)
	);

	cet_mem u_mem (
		.clk   (clk),
		.req   (mem_req),
		.rdata (mem_rdata)
	);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		entry_count <= cet_pkg::CNT_OUT_W'(cet_pkg::MAX_ENTRIES))
		else $error("entry count above capacity");

	a_quick_ops: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (operation == cet_pkg::OP_WRITE ||
		operation == cet_pkg::OP_CLEAR) |=> done)
		else $error("write or clear did not finish in one cycle");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !ok |-> read_data == '0)
		else $error("failed request carries read data");

	a_busy_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("sequencer went idle without a result");

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for compacting_entry_table_unit. Words go in through
// the start/busy handshake with random gaps. A local copy of the table
// predicts ok, read_data and entry_count for every accepted word. Directed
// tests cover the empty, full and out-of-range cases and the longest delete.
// Random traffic follows, mostly with indexes at or below the live count.
// ----------------------------------------------------------------------------
module tb_top;
	import cet_pkg::*;

	localparam int CLK_HALF     = 10;
	localparam int LIMIT_CYCLES = 1000000;
	localparam int TAIL_CYCLES  = 40;
	localparam int RANDOM_WORDS = 1650;

	typedef struct packed {
		logic                 ok;
		logic [DATA_W-1:0]    rdata;
		logic [CNT_OUT_W-1:0] count;
	} result_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic [OP_W-1:0]      operation = '0;
	logic [IDX_W-1:0]     index = '0;
	logic [DATA_W-1:0]    entry_data = '0;
	logic                 busy;
	logic                 done;
	logic                 ok;
	logic [DATA_W-1:0]    read_data;
	logic [CNT_OUT_W-1:0] entry_count;

	result_t              pending_results[$];
	logic [ENTRY_WIDTH-1:0] entry_mem [MAX_ENTRIES];
	int                   live_count = 0;
	int                   errors = 0;
	int                   cycles = 0;
	bit                   paced = 1'b1;

	always #(CLK_HALF) clk = ~clk;

	compacting_entry_table_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.operation(operation),
		.index(index),
		.entry_data(entry_data),
		.done(done),
		.ok(ok),
		.read_data(read_data),
		.entry_count(entry_count)
	);

	function automatic void table_apply(op_t op, logic [IDX_W-1:0] idx,
			logic [DATA_W-1:0] data);
		result_t r;
		int a;
		r.ok = 1'b0;
		r.rdata = '0;
		a = int'(idx);
		case (op)
			OP_READ: begin
				if (a < live_count) begin
					r.rdata = DATA_W'(entry_mem[a]);
					r.ok = 1'b1;
				end
			end
			OP_WRITE: begin
				if (a < live_count) begin
					entry_mem[a] = ENTRY_WIDTH'(data);
					r.ok = 1'b1;
				end else if (a == live_count && live_count < MAX_ENTRIES) begin
					entry_mem[a] = ENTRY_WIDTH'(data);
					live_count++;
					r.ok = 1'b1;
				end
			end
			OP_DELETE: begin
				if (a < live_count) begin
					for (int i = a; i + 1 < live_count; i++)
						entry_mem[i] = entry_mem[i + 1];
					live_count--;
					r.ok = 1'b1;
				end
			end
			default: begin
				live_count = 0;
				r.ok = 1'b1;
			end
		endcase
		r.count = CNT_OUT_W'(live_count);
		pending_results.push_back(r);
	endfunction

	function automatic logic [DATA_W-1:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	task automatic idle_gap();
		int r;
		int n;
		r = $urandom_range(0, 99);
		if (!paced || r < 50)
			n = 0;
		else if (r < 85)
			n = $urandom_range(1, 3);
		else if (r < 97)
			n = $urandom_range(4, 12);
		else
			n = $urandom_range(20, 60);
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// start stays high on return; the next call lowers it or reloads the word
	task automatic send_word(op_t op, logic [IDX_W-1:0] idx, logic [DATA_W-1:0] data);
		idle_gap();
		start      <= 1'b1;
		operation  <= op;
		index      <= idx;
		entry_data <= data;
		do @(posedge clk); while (busy);
		table_apply(op, idx, data);
	endtask

	task automatic wait_for_results();
		start <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	task automatic test_empty_table();
		send_word(OP_READ, 8'd0, rand_word());
		send_word(OP_DELETE, 8'd0, rand_word());
		send_word(OP_WRITE, 8'd1, rand_word());
		send_word(OP_CLEAR, 8'd0, rand_word());
	endtask

	task automatic test_append_and_read();
		send_word(OP_WRITE, 8'd0, '0);
		send_word(OP_WRITE, 8'd1, '1);
		send_word(OP_WRITE, 8'd2, rand_word());
		send_word(OP_READ, 8'd0, '1);
		send_word(OP_READ, 8'd1, '0);
		send_word(OP_READ, 8'd2, rand_word());
		send_word(OP_READ, 8'd3, rand_word());
	endtask

	task automatic test_overwrite();
		send_word(OP_WRITE, 8'd1, rand_word());
		send_word(OP_READ, 8'd1, rand_word());
	endtask

	task automatic test_out_of_range();
		send_word(OP_READ, 8'd255, '1);
		send_word(OP_WRITE, 8'd255, '1);
		send_word(OP_DELETE, 8'd255, '1);
		send_word(OP_DELETE, 8'(live_count), rand_word());
	endtask

	task automatic test_full_table();
		while (live_count < MAX_ENTRIES)
			send_word(OP_WRITE, 8'(live_count), rand_word());
		send_word(OP_WRITE, 8'(MAX_ENTRIES), rand_word());
		send_word(OP_READ, 8'(MAX_ENTRIES - 1), rand_word());
		send_word(OP_DELETE, 8'd0, rand_word());
		send_word(OP_READ, 8'd0, rand_word());
		send_word(OP_DELETE, 8'(live_count - 1), rand_word());
		send_word(OP_DELETE, 8'd5, rand_word());
		send_word(OP_READ, 8'd5, rand_word());
		send_word(OP_CLEAR, 8'd255, '1);
		send_word(OP_READ, 8'd0, rand_word());
	endtask

	task automatic test_drain();
		send_word(OP_WRITE, 8'(live_count), rand_word());
		wait_for_results();
		send_word(OP_READ, 8'd0, rand_word());
	endtask

	// indexes stay mostly at or below the count so the table fills and empties
	task automatic test_random_traffic();
		int r;
		op_t op;
		logic [IDX_W-1:0] idx;
		for (int n = 0; n < RANDOM_WORDS; n++) begin
			if (n % 50 == 0)
				paced = ($urandom_range(0, 3) != 0);
			if (n % 250 == 249)
				wait_for_results();
			r = $urandom_range(0, 99);
			if (r < 30)
				op = OP_READ;
			else if (r < 75)
				op = OP_WRITE;
			else if (r < 95)
				op = OP_DELETE;
			else
				op = OP_CLEAR;
			r = $urandom_range(0, 99);
			if (op == OP_WRITE && r < 50)
				idx = 8'(live_count);
			else if (r < 85)
				idx = 8'($urandom_range(0, live_count));
			else if (r < 95)
				idx = 8'($urandom_range(0, 31));
			else
				idx = 8'($urandom_range(0, 255));
			send_word(op, idx, rand_word());
		end
		paced = 1'b1;
	endtask

	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result, ok %0d read_data %h entry_count %0d",
					$time, ok, read_data, entry_count);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (ok !== want.ok) begin
					$display("%0t: ok mismatch, expected %0d actual %0d",
						$time, want.ok, ok);
					errors++;
				end
				if (read_data !== want.rdata) begin
					$display("%0t: read_data mismatch, expected %h actual %h",
						$time, want.rdata, read_data);
					errors++;
				end
				if (entry_count !== want.count) begin
					$display("%0t: entry_count mismatch, expected %0d actual %0d",
						$time, want.count, entry_count);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_empty_table();
		test_append_and_read();
		test_overwrite();
		test_out_of_range();
		test_full_table();
		test_drain();
		test_random_traffic();
		start <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
